@@ hw/rtl/ckmer_pkg.sv @@
// ckmer_pkg: shared types and constants for the canonical k-mer stream block
// used by ckmer_cell, ckmer_out and canonical_kmer_stream_top; no dependencies

package ckmer_pkg;

  // widths fixed by the stream format
  localparam int unsigned NucW     = 8;
  localparam int unsigned BaseW    = 2;
  localparam int unsigned KLenW    = 6;
  localparam int unsigned KmerW    = 64;
  localparam int unsigned MaxKmer  = 32;
  localparam int unsigned KLenRst  = 27;

  // complement of a 2-bit base code flips the upper bit
  localparam logic [BaseW-1:0] CompFlip = 2'b10;

  typedef logic [BaseW-1:0] base_t;
  typedef logic [KLenW-1:0] klen_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic  shift;   // a nucleotide transaction is taken this cycle
    logic  clear;   // first nucleotide of a new sequence
    klen_t k;       // effective k-mer length, 1..MAX_KMER
    base_t comp;    // complement code entering the reverse register
  } cell_ctl_t;

endpackage

@@ hw/rtl/ckmer_cell.sv @@
// ckmer_cell: one base position of the forward and reverse-complement k-mers
// depends on ckmer_pkg

module ckmer_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ckmer_pkg::cell_ctl_t ctl_i,
  input  ckmer_pkg::base_t     fwd_i,   // from the next lower cell (code at cell 0)
  input  ckmer_pkg::base_t     rev_i,   // from the next higher cell
  output ckmer_pkg::base_t     fwd_o,
  output ckmer_pkg::base_t     rev_o
);

  localparam ckmer_pkg::klen_t IdxK = ckmer_pkg::KLenW'(Idx);

  ckmer_pkg::base_t fwd_q, fwd_d;
  ckmer_pkg::base_t rev_q, rev_d;
  logic             active;
  logic             is_top;
  ckmer_pkg::base_t fwd_nbr;
  ckmer_pkg::base_t rev_nbr;

  // position inside the current k-mer window
  assign active = IdxK < ctl_i.k;
  assign is_top = IdxK == (ctl_i.k - ckmer_pkg::KLenW'(1));

  // neighbor data, dropped on a sequence restart (new code still enters cell 0)
  assign fwd_nbr = (ctl_i.clear && (Idx != 0)) ? '0 : fwd_i;
  assign rev_nbr = ctl_i.clear ? '0 : rev_i;

  // shift forward up, reverse down, insert complement at the window top
  always_comb begin
    fwd_d = fwd_q;
    rev_d = rev_q;
    if (ctl_i.shift) begin
      fwd_d = active ? fwd_nbr : '0;
      rev_d = active ? (rev_nbr | (is_top ? ctl_i.comp : '0)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
    end else begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

@@ hw/rtl/ckmer_out.sv @@
// ckmer_out: canonical pick (minimum of both strands) and output register
// depends on ckmer_pkg

module ckmer_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pend_i,   // cells hold an unsent result
  input  logic [ckmer_pkg::KmerW-1:0]   fwd_i,
  input  logic [ckmer_pkg::KmerW-1:0]   rev_i,
  output logic                          free_o,   // result register can load
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ckmer_pkg::KmerW-1:0]   m_axis_tdata
);

  logic                        valid_q, valid_d;
  logic [ckmer_pkg::KmerW-1:0] data_q, data_d;
  logic                        load;

  assign free_o = !valid_q || m_axis_tready;
  assign load   = free_o && pend_i;

  // smaller of forward and reverse-complement
  always_comb begin
    valid_d = free_o ? pend_i : valid_q;
    data_d  = data_q;
    if (load) begin
      data_d = (fwd_i < rev_i) ? fwd_i : rev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

@@ hw/rtl/canonical_kmer_stream_top.sv @@
// canonical_kmer_stream_top: rolling canonical k-mer encoder, a chain of base cells
// depends on ckmer_pkg, ckmer_cell, ckmer_out
//
//   channel   dir  data                              handshake
//   s_axis    in   tdata: nucleotide[7:0]            tvalid/tready
//                  tuser: new_sequence[0]
//   m_axis    out  tdata: canonical_kmer[63:0]       tvalid/tready
//   cfg       in   cfg_data_i: kmer_length[5:0]      cfg_valid_i/cfg_ready_o
//
// One nucleotide per cycle while s_axis_tready is high. The cells shift and the pending
// flag sets on input; the compare then loads the output register, raising m_axis_tvalid.
// The 64-bit strand compare between the cell row and the output register sets the path.
// Reset clears all cells, the fill count and the output valid; kmer_length resets to 27.
// With the output held, input is taken until a result pends; then s_axis_tready drops.

module canonical_kmer_stream_top #(
  parameter int unsigned MAX_KMER = ckmer_pkg::MaxKmer
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ckmer_pkg::NucW-1:0]          s_axis_tdata,   // [7:0] nucleotide
  input  logic                                s_axis_tuser,   // [0] new_sequence
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ckmer_pkg::KmerW-1:0]         m_axis_tdata,   // [63:0] canonical_kmer
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ckmer_pkg::KLenW-1:0]         cfg_data_i      // [5:0] kmer_length
);

  localparam int unsigned      BaseW = ckmer_pkg::BaseW;
  localparam ckmer_pkg::klen_t MaxK  = ckmer_pkg::KLenW'(MAX_KMER);

  ckmer_pkg::klen_t     klen_q, klen_d;
  ckmer_pkg::klen_t     k_eff;
  ckmer_pkg::klen_t     fill_q, fill_d, fill_base;
  logic                 pend_q, pend_d;
  logic                 accept;
  logic                 out_free;
  logic                 emit;
  ckmer_pkg::base_t     code;
  ckmer_pkg::cell_ctl_t ctl;

  ckmer_pkg::base_t fwd_cell [MAX_KMER];
  ckmer_pkg::base_t rev_cell [MAX_KMER];
  logic [ckmer_pkg::KmerW-1:0] fwd_vec;
  logic [ckmer_pkg::KmerW-1:0] rev_vec;

  // configuration register
  assign cfg_ready_o = 1'b1;
  assign klen_d      = cfg_valid_i ? cfg_data_i : klen_q;

  // clamp k into 1..MAX_KMER
  always_comb begin
    k_eff = klen_q;
    if (klen_q == '0) begin
      k_eff = ckmer_pkg::KLenW'(1);
    end else if (klen_q > MaxK) begin
      k_eff = MaxK;
    end
  end

  // input handshake: blocked only while a result waits behind a held output
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !pend_q || out_free;

  assign code = s_axis_tdata[BaseW:1];

  assign ctl.shift = accept;
  assign ctl.clear = s_axis_tuser;
  assign ctl.k     = k_eff;
  assign ctl.comp  = code ^ ckmer_pkg::CompFlip;

  // fill count saturates at k
  assign fill_base = s_axis_tuser ? '0 : fill_q;
  always_comb begin
    fill_d = fill_q;
    if (accept && (fill_base < k_eff)) begin
      fill_d = fill_base + ckmer_pkg::KLenW'(1);
    end else if (accept) begin
      fill_d = fill_base;
    end
  end
  assign emit = fill_d >= k_eff;

  // pending result flag between cell row and output register
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = emit;
    end else if (out_free) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= ckmer_pkg::KLenW'(ckmer_pkg::KLenRst);
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      klen_q <= klen_d;
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  // row of base cells, forward data moves up, reverse data moves down
  for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
    ckmer_pkg::base_t fwd_in;
    ckmer_pkg::base_t rev_in;

    if (i == 0) begin : g_first
      assign fwd_in = code;
    end else begin : g_mid
      assign fwd_in = fwd_cell[i-1];
    end

    if (i == MAX_KMER - 1) begin : g_last
      assign rev_in = '0;
    end else begin : g_inner
      assign rev_in = rev_cell[i+1];
    end

    ckmer_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .fwd_i  (fwd_in),
      .rev_i  (rev_in),
      .fwd_o  (fwd_cell[i]),
      .rev_o  (rev_cell[i])
    );

    assign fwd_vec[BaseW*i +: BaseW] = fwd_cell[i];
    assign rev_vec[BaseW*i +: BaseW] = rev_cell[i];
  end

  // positions beyond the longest k-mer stay zero
  if (BaseW * MAX_KMER < ckmer_pkg::KmerW) begin : g_pad
    assign fwd_vec[ckmer_pkg::KmerW-1:BaseW*MAX_KMER] = '0;
    assign rev_vec[ckmer_pkg::KmerW-1:BaseW*MAX_KMER] = '0;
  end

  ckmer_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pend_i        (pend_q),
    .fwd_i         (fwd_vec),
    .rev_i         (rev_vec),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ hw/rtl/ckmer_checker.sv @@
// ckmer_checker: port-level checks for canonical_kmer_stream_top, with its bind
// depends on ckmer_pkg and the top level ports

module ckmer_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ckmer_pkg::KmerW-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // held result keeps its valid and data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // input backpressure only while a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // no result appears without an input transaction in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_acc && !m_axis_tvalid) ##1 (!s_acc && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result without input transaction");

  // output stays empty right after reset
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind canonical_kmer_stream_top ckmer_checker u_ckmer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_canonical_kmer_stream_top.sv @@
// tb_canonical_kmer_stream_top: self-checking testbench for the canonical k-mer stream
// depends on ckmer_pkg and canonical_kmer_stream_top; a rolling-window class tracks results
`timescale 1ns / 1ps

module tb_canonical_kmer_stream_top;

  localparam int ClkHalf = 6;

  // rolling window of the current sequence, tracks the k-mers the block must emit
  class canonical_window;
    logic [ckmer_pkg::KmerW-1:0] fwd_strand;
    logic [ckmer_pkg::KmerW-1:0] rev_strand;
    ckmer_pkg::klen_t            fill;
    ckmer_pkg::klen_t            klen;
    logic [ckmer_pkg::KmerW-1:0] due_kmers[$];
    int unsigned                 kmer_errors;

    function new();
      fwd_strand  = '0;
      rev_strand  = '0;
      fill        = '0;
      klen        = ckmer_pkg::klen_t'(ckmer_pkg::KLenRst);
      kmer_errors = 0;
    endfunction

    function void set_length(ckmer_pkg::klen_t value);
      klen = value;
    endfunction

    // k clamped to 1..MaxKmer
    function int unsigned eff_k();
      if (klen == 0) return 1;
      if (klen > ckmer_pkg::MaxKmer) return ckmer_pkg::MaxKmer;
      return klen;
    endfunction

    function int unsigned pending();
      return due_kmers.size();
    endfunction

    // roll one accepted nucleotide into both strands
    function void take_base(logic [ckmer_pkg::NucW-1:0] nuc, logic new_seq);
      int unsigned                 k;
      logic [ckmer_pkg::KmerW-1:0] mask;
      logic [ckmer_pkg::KmerW-1:0] canon;
      ckmer_pkg::base_t            code;
      ckmer_pkg::base_t            comp;
      k    = eff_k();
      mask = (k >= ckmer_pkg::KmerW / 2) ? '1 :
             (ckmer_pkg::KmerW'(1) << (2 * k)) - ckmer_pkg::KmerW'(1);
      code = nuc[2:1];
      comp = code ^ ckmer_pkg::CompFlip;
      if (new_seq) begin
        fwd_strand = '0;
        rev_strand = '0;
        fill       = '0;
      end
      fwd_strand = ((fwd_strand << 2) | ckmer_pkg::KmerW'(code)) & mask;
      rev_strand = ((rev_strand >> 2) | (ckmer_pkg::KmerW'(comp) << (2 * (k - 1)))) & mask;
      if (fill < k) fill = fill + 1'b1;
      if (fill >= k) begin
        canon     = (fwd_strand < rev_strand) ? fwd_strand : rev_strand;
        due_kmers = {due_kmers, canon};
      end
    endfunction

    function void flag_error(string what, logic [ckmer_pkg::KmerW-1:0] want,
                             logic [ckmer_pkg::KmerW-1:0] got);
      kmer_errors++;
      if (kmer_errors <= 10)
        $display("%0t: %s: canonical_kmer expected %h got %h", $realtime, what, want, got);
    endfunction

    // compare one emitted k-mer with the oldest one due
    function void match_kmer(logic [ckmer_pkg::KmerW-1:0] got);
      logic [ckmer_pkg::KmerW-1:0] want;
      if (due_kmers.size() == 0) begin
        flag_error("unexpected k-mer", 'x, got);
        return;
      end
      want = due_kmers.pop_front();
      if (got !== want) flag_error("k-mer mismatch", want, got);
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ckmer_pkg::NucW-1:0]    s_axis_tdata  = '0;
  logic                          s_axis_tuser  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ckmer_pkg::KmerW-1:0]   m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [ckmer_pkg::KLenW-1:0]   cfg_data_i    = '0;

  canonical_window window = new();
  int unsigned     burst_left = 0;
  bit              hold_req = 1'b0;
  string           bases = "ACGTacgt";

  canonical_kmer_stream_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] nucleotide
    .s_axis_tuser  (s_axis_tuser),   // [0] new_sequence
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] canonical_kmer
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)      // [5:0] kmer_length
  );

  // clock
  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(2 * ClkHalf * 300000);
    $display("** canonical_kmer_stream_top: FAILED **");
    $finish;
  end

  // check every output transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) window.match_kmer(m_axis_tdata);
  end

  // receiver stalls in stretches of varying density, plus one long hold-off on request
  initial begin
    int unsigned stall_pct;
    int unsigned stretch;
    @(posedge rst_ni);
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        if (hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (200) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // offer one nucleotide in bursts with random gaps, return once accepted
  task automatic send_base(input logic [ckmer_pkg::NucW-1:0] nuc, input logic new_seq);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nuc;
    s_axis_tuser  <= new_seq;
    do @(posedge clk_i); while (!s_axis_tready);
    window.take_base(nuc, new_seq);
    burst_left--;
  endtask

  // stop sending and wait until every due k-mer has come out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (window.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_length(input ckmer_pkg::klen_t value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window.set_length(value);
  endtask

  // random sequences up to k+24 long, mostly clean letters, some short or noisy
  task automatic run_phase(input int unsigned n_items, input bit pause_mid);
    int unsigned                sent;
    int unsigned                len;
    int unsigned                k;
    bit                         clean;
    bit                         new_seq;
    logic [ckmer_pkg::NucW-1:0] nuc;
    k = window.eff_k();
    sent = 0;
    while (sent < n_items) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, k + 24);
      clean = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len && sent < n_items; i++) begin
        if (clean && $urandom_range(0, 19) != 0) nuc = bases[$urandom_range(0, 7)];
        else nuc = ckmer_pkg::NucW'($urandom_range(0, 255));
        // the first sequence of a phase may carry on across the length change
        new_seq = (i == 0 && (sent != 0 || $urandom_range(0, 1) == 1)) ||
                  ($urandom_range(0, 99) == 0);
        send_base(nuc, new_seq);
        sent++;
        if (pause_mid && sent == n_items / 2) drain();
      end
    end
  endtask

  // stimulus
  initial begin
    logic [ckmer_pkg::NucW-1:0] pattern[12];
    ckmer_pkg::klen_t           lengths[13];
    pattern = '{"A", "C", "G", "T", "a", "c", "g", "t", 8'h00, 8'hFF, 8'h55, 8'hAA};
    lengths = '{6'd1, 6'd0, 6'd32, 6'd63, 6'd5, 6'd33, 6'd16, 6'd2, 6'd27, 6'd9,
                ckmer_pkg::klen_t'($urandom_range(0, 63)),
                ckmer_pkg::klen_t'($urandom_range(0, 63)),
                ckmer_pkg::klen_t'($urandom_range(0, 63))};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length: all letter cases and byte extremes, just past k
    for (int i = 0; i < 28; i++) send_base(pattern[i % 12], i == 0);
    drain();
    // k of one, a fresh sequence started mid-stream
    write_length(6'd1);
    send_base("G", 1'b1);
    send_base("T", 1'b0);
    send_base(8'hFF, 1'b0);
    send_base("A", 1'b1);
    drain();
    // zero acts as one
    write_length(6'd0);
    send_base("c", 1'b0);
    send_base(8'h00, 1'b1);
    drain();
    // oversized length acts as the maximum, kept mid-sequence
    write_length(6'd63);
    send_base("g", 1'b0);
    send_base("T", 1'b0);
    drain();

    foreach (lengths[p]) begin
      write_length(lengths[p]);
      if (p == 3) hold_req = 1'b1;
      run_phase(100, p == 6);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (window.pending() != 0)
      $display("%0d k-mers never came out", window.pending());
    if (window.kmer_errors == 0 && window.pending() == 0) begin
      $display("** canonical_kmer_stream_top: PASSED **");
    end else begin
      $display("** canonical_kmer_stream_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ckmer_pkg.sv
hw/rtl/ckmer_cell.sv
hw/rtl/ckmer_out.sv
hw/rtl/canonical_kmer_stream_top.sv
hw/rtl/ckmer_checker.sv
tb/tb_canonical_kmer_stream_top.sv
